[rtl/signed_int_to_decimal_ascii_defines.svh]
// Assertion macros for the signed integer to decimal ASCII converter.
// Used by the top level only; compiled to nothing when SYNTHESIS is set.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTHESIS
`define SIDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define SIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define SIDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/sida_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII converter.
// No dependencies.
`timescale 1ns / 1ps

package sida_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 7;
  localparam int NUM_DIGITS = 10;
  localparam int POS_W      = 4;
  localparam int DIGIT_W    = 4;
  localparam int THR_W      = 34;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'd57;

  localparam logic [POS_W-1:0] TOP_POS = 4'd9;

  localparam logic [THR_W-1:0] POW10 [NUM_DIGITS] = '{
    34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
    34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
  };

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

[rtl/sida_front.sv]
// Front stage: accepts the signed value, splits it into sign and magnitude.
// Depends on sida_pkg.
`timescale 1ns / 1ps

module sida_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [sida_pkg::VALUE_W-1:0] in_value,
  output logic                          f_valid,
  input  logic                          f_ready,
  output sida_pkg::item_t               f_item
);

  logic            valid_r, valid_nxt;
  sida_pkg::item_t item_r, item_nxt;
  logic [sida_pkg::VALUE_W-1:0] raw;

  assign in_ready = !valid_r || f_ready;
  assign f_valid  = valid_r;
  assign f_item   = item_r;
  assign raw      = in_value;

  always_comb begin
    valid_nxt = valid_r && !f_ready;
    item_nxt  = item_r;
    if (in_valid && in_ready) begin
      valid_nxt    = 1'b1;
      item_nxt.neg = raw[sida_pkg::VALUE_W-1];
      item_nxt.mag = raw[sida_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

[rtl/sida_queue.sv]
// Two-entry queue of classified items between front and back.
// Depends on sida_pkg.
`timescale 1ns / 1ps

module sida_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  sida_pkg::item_t       push_item,
  output sida_pkg::queue_head_t head,
  input  logic                  pop
);

  sida_pkg::item_t              mem_r [sida_pkg::QDEPTH];
  logic [sida_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [sida_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [sida_pkg::QCNT_W-1:0]  count_r, count_nxt;
  logic                         do_push, do_pop;

  assign push_ready = (count_r != sida_pkg::QCNT_W'(sida_pkg::QDEPTH));
  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == sida_pkg::QPTR_W'(sida_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sida_pkg::QPTR_W'(sida_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/sida_back.sv]
// Back stage: emits sign and decimal digits, one decimal place per cycle unless out_ready stalls it.
// Depends on sida_pkg.
`timescale 1ns / 1ps

module sida_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sida_pkg::queue_head_t         head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sida_pkg::CHAR_W-1:0]   out_char_code,
  output logic                          out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [sida_pkg::VALUE_W-1:0]   mag_r, mag_nxt;
  logic [sida_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic                           started_r, started_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [sida_pkg::CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [sida_pkg::THR_W-1:0]     thr [sida_pkg::NUM_DIGITS][10];
  logic [9:1]                     ge;
  logic [sida_pkg::DIGIT_W-1:0]   digit;
  logic [sida_pkg::VALUE_W-1:0]   rem;
  logic                           adv, emit;

  for (genvar gp = 0; gp < sida_pkg::NUM_DIGITS; gp++) begin : g_pos
    for (genvar gk = 0; gk < 10; gk++) begin : g_mult
      assign thr[gp][gk] = sida_pkg::POW10[gp] * sida_pkg::THR_W'(gk);
    end
  end

  always_comb begin
    ge    = '0;
    digit = '0;
    for (int k = 1; k < 10; k++) begin
      ge[k] = ({2'b00, mag_r} >= thr[pos_r][k]);
    end
    for (int k = 1; k < 10; k++) begin
      if (ge[k]) begin
        digit = sida_pkg::DIGIT_W'(k);
      end
    end
  end

  assign rem           = mag_r - thr[pos_r][digit][sida_pkg::VALUE_W-1:0];
  assign adv           = !out_valid_r || out_ready;
  assign emit          = (digit != '0) || started_r || (pos_r == '0);
  assign pop           = (state_r == ST_IDLE) && head.valid;
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    pos_nxt       = pos_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          mag_nxt     = head.item.mag;
          pos_nxt     = sida_pkg::TOP_POS;
          started_nxt = 1'b0;
          state_nxt   = head.item.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sida_pkg::ASCII_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (adv) begin
          mag_nxt = rem;
          if (emit) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = sida_pkg::ASCII_ZERO + sida_pkg::CHAR_W'(digit);
            out_last_nxt  = (pos_r == '0);
            started_nxt   = 1'b1;
          end
          if (pos_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    pos_r      <= pos_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// Top level: signed 32-bit integer to decimal ASCII character stream.
// Depends on sida_pkg, sida_front, sida_queue, sida_back and the defines header.
//
//   channel  ports                          width  dir
//   in       in_valid/in_ready, in_value    32 s   in
//   out      out_valid/out_ready,           7 + 1  out
//            out_char_code, out_last
//
// For each item the back stage loads it from the queue, emits a minus sign if it is
// negative, then steps through each decimal place from 10^9 down to 10^0; leading
// zeros use their step unsent. The front register and a two-entry queue take
// further items during that time. Synchronous active-low reset empties all stages;
// out_ready low while out_valid is high holds the output register and stalls the
// back stage, then the queue and front fill behind it.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sida_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sida_pkg::CHAR_W-1:0]         out_char_code,
  output logic                                out_last
);

  logic                  f_valid, f_ready, q_pop;
  sida_pkg::item_t       f_item;
  sida_pkg::queue_head_t q_head;
  logic                  out_is_minus, out_is_digit;

  sida_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_item   (f_item)
  );

  sida_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .head       (q_head),
    .pop        (q_pop)
  );

  sida_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  assign out_is_minus = (out_char_code == sida_pkg::ASCII_MINUS);
  assign out_is_digit = (out_char_code >= sida_pkg::ASCII_ZERO) &&
                        (out_char_code <= sida_pkg::ASCII_NINE);

  `SIDA_ASSERT_IMPLY(a_minus_not_last, clk, rst_n, out_valid && out_is_minus, !out_last)
  `SIDA_ASSERT_IMPLY(a_char_legal, clk, rst_n, out_valid, out_is_minus || out_is_digit)
  `SIDA_ASSERT_NEXT(a_push_fills_queue, clk, rst_n, f_valid && f_ready, q_head.valid)

endmodule
